### rtl/bpc_pkg.sv
// shared types, constants and arithmetic helpers for the pressure compensation pipeline
package bpc_pkg;

	localparam int NumRegs = 5;
	localparam int RegIdxW = 3;
	localparam int DivW = 32;

	localparam logic [RegIdxW-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [RegIdxW-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [RegIdxW-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [RegIdxW-1:0] REG_B1_B2 = 3'd3;
	localparam logic [RegIdxW-1:0] REG_MC_MD = 3'd4;

	localparam logic [31:0] K_B6_OFS = 32'd4000;
	localparam logic [31:0] K_B7_MUL = 32'd50000;
	localparam logic [31:0] K_B4_OFS = 32'd32768;
	localparam logic [31:0] K_P_X1 = 32'd3038;
	localparam logic [31:0] K_P_X2 = 32'hFFFF_E343;
	localparam logic [31:0] K_P_OFS = 32'd3791;

	// one divider cell: a numerator being shifted out, a partial remainder, a quotient
	typedef struct packed {
		logic        vld;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] rem;
		logic [31:0] quo;
	} div_cell_t;

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

### rtl/bpc_div_cell.sv
// one restoring division step, registered, passed to the next cell
module bpc_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  bpc_pkg::div_cell_t din,
	output bpc_pkg::div_cell_t dout
);
	import bpc_pkg::*;

	logic [32:0] trial;
	logic [32:0] diff;
	logic        vld_q;
	logic [31:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;

	always_comb begin
		trial = {din.rem, din.num[31]};
		diff = trial - {1'b0, din.den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q <= {din.num[30:0], 1'b0};
			den_q <= din.den;
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
			quo_q <= {din.quo[30:0], ~diff[32]};
		end
	end

	assign dout = '{vld: vld_q, num: num_q, den: den_q, rem: rem_q, quo: quo_q};
endmodule

### rtl/bpc_divider.sv
// unsigned 32-bit divider as a chain of one-bit cells with a side payload carried alongside
module bpc_divider #(
	parameter int SideW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [31:0]       in_num,
	input  logic [31:0]       in_den,
	input  logic [SideW-1:0]  in_side,
	output logic              out_vld,
	output logic [31:0]       out_quo,
	output logic [SideW-1:0]  out_side
);
	import bpc_pkg::*;

	div_cell_t chain [DivW+1];
	logic [SideW-1:0] side_q [DivW];

	assign chain[0] = '{vld: in_vld, num: in_num, den: in_den, rem: '0, quo: '0};

	for (genvar i = 0; i < DivW; i++) begin : g_cell
		bpc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i] <= (i == 0) ? in_side : side_q[(i == 0) ? 0 : i-1];
			end
		end
	end

	assign out_vld = chain[DivW].vld;
	assign out_quo = chain[DivW].quo;
	assign out_side = side_q[DivW-1];
endmodule

### rtl/barometric_pressure_compensation.sv
// top level: coefficient registers, compensation pipeline with two cell-chain dividers
//
// channel  dir  tdata / fields
// s_axis   in   [15:0] raw_temp, [31:16] raw_pressure
// m_axis   out  [31:0] pressure_pa, tuser[0] divide_fault
// cfg      in   cfg_idx selects register, cfg_data written
//
// one item per cycle unless the output stalls; two 32-cell dividers plus 13 stages
// the whole pipe advances when the output register is empty or being taken
// reset clears valid flags and the five coefficient registers
// cfg_ready is always high
module barometric_pressure_compensation #(
	parameter int NRegs = bpc_pkg::NumRegs
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // raw_temp, raw_pressure
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,  // pressure_pa
	output logic                         m_axis_tuser,  // divide_fault
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bpc_pkg::RegIdxW-1:0]  cfg_idx,
	input  logic [31:0]                  cfg_data
);
	import bpc_pkg::*;

	logic [31:0] coef_q [NRegs];
	logic en;

	assign cfg_ready = 1'b1;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NRegs; i++) coef_q[i] <= '0;
		end else if (cfg_valid && 32'(cfg_idx) < NRegs) begin
			coef_q[cfg_idx] <= cfg_data;
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
	always_comb begin
		ac1 = sx16(coef_q[REG_AC1_AC2][31:16]);
		ac2 = sx16(coef_q[REG_AC1_AC2][15:0]);
		ac3 = sx16(coef_q[REG_AC3_AC4][31:16]);
		ac4 = {16'd0, coef_q[REG_AC3_AC4][15:0]};
		ac5 = {16'd0, coef_q[REG_AC5_AC6][31:16]};
		ac6 = {16'd0, coef_q[REG_AC5_AC6][15:0]};
		cb1 = sx16(coef_q[REG_B1_B2][31:16]);
		cb2 = sx16(coef_q[REG_B1_B2][15:0]);
		mc = sx16(coef_q[REG_MC_MD][31:16]);
		md = sx16(coef_q[REG_MC_MD][15:0]);
	end

	logic v_s1, v_s2;
	logic [31:0] m_s1, x1_s2, den_s2, dn_s2, dd_s2;
	logic [15:0] up_s1, up_s2;
	logic ng_s2, fz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mul32({16'd0, s_axis_tdata[15:0]} - ac6, ac5);
			up_s1 <= s_axis_tdata[31:16];
			x1_s2 <= asr(m_s1, 15);
			den_s2 <= asr(m_s1, 15) + md;
			up_s2 <= up_s1;
		end
	end

	logic [31:0] tnum;
	assign tnum = mc << 11;
	always_comb begin
		dn_s2 = tnum[31] ? -tnum : tnum;
		dd_s2 = den_s2[31] ? -den_s2 : den_s2;
		ng_s2 = tnum[31] ^ den_s2[31];
		fz_s2 = den_s2 == '0;
	end

	localparam int SW1 = 32 + 16 + 2;
	logic dv1_vld;
	logic [31:0] dv1_q;
	logic [SW1-1:0] dv1_side;

	bpc_divider #(.SideW(SW1)) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s2),
		.in_num   (dn_s2),
		.in_den   (dd_s2),
		.in_side  ({x1_s2, up_s2, ng_s2, fz_s2}),
		.out_vld  (dv1_vld),
		.out_quo  (dv1_q),
		.out_side (dv1_side)
	);

	logic [31:0] x1_d;
	logic [15:0] up_d;
	logic ng_d, fz_d;
	assign {x1_d, up_d, ng_d, fz_d} = dv1_side;

	logic v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [31:0] b6_s3, sq_s4, p1_s4, p2_s4;
	logic [31:0] sq_s5, t1_s5, t2_s5, a1_s5, a3_s5, b1_s5;
	logic [31:0] b3_s6, x3_s6, b3_s7, b4_s7, b7_s8, b4_s8;
	logic [31:0] m4_s6;
	logic [15:0] up_s3, up_s4, up_s5, up_s6, up_s7;
	logic f_s3, f_s4, f_s5, f_s6, f_s7, f_s8;
	logic [31:0] x2q;

	assign x2q = ng_d ? -dv1_q : dv1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			{v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= {dv1_vld, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s3 <= x1_d + x2q - K_B6_OFS;
			up_s3 <= up_d;
			f_s3 <= fz_d;
			sq_s4 <= mul32(b6_s3, b6_s3);
			p1_s4 <= mul32(ac2, b6_s3);
			p2_s4 <= mul32(ac3, b6_s3);
			up_s4 <= up_s3;
			f_s4 <= f_s3;
			sq_s5 <= asr(sq_s4, 12);
			t1_s5 <= asr(p1_s4, 11);
			t2_s5 <= asr(p2_s4, 13);
			a1_s5 <= ac1 << 2;
			a3_s5 <= ac4;
			b1_s5 <= cb1;
			up_s5 <= up_s4;
			f_s5 <= f_s4;
			b3_s6 <= asr(a1_s5 + asr(mul32(cb2, sq_s5), 11) + t1_s5 + 32'd2, 2);
			x3_s6 <= asr(t2_s5 + asr(mul32(b1_s5, sq_s5), 16) + 32'd2, 2);
			m4_s6 <= a3_s5;
			up_s6 <= up_s5;
			f_s6 <= f_s5;
			b3_s7 <= b3_s6;
			b4_s7 <= mul32(m4_s6, x3_s6 + K_B4_OFS) >> 15;
			up_s7 <= up_s6;
			f_s7 <= f_s6;
			b7_s8 <= mul32({16'd0, up_s7} - b3_s7, K_B7_MUL);
			b4_s8 <= b4_s7;
			f_s8 <= f_s7 || (b4_s7 == '0);
		end
	end

	logic dv2_vld;
	logic [31:0] dv2_q;
	logic [1:0] dv2_side;

	bpc_divider #(.SideW(2)) u_div_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s8),
		.in_num   (b7_s8[31] ? b7_s8 : (b7_s8 << 1)),
		.in_den   (b4_s8),
		.in_side  ({b7_s8[31], f_s8}),
		.out_vld  (dv2_vld),
		.out_quo  (dv2_q),
		.out_side (dv2_side)
	);

	logic v_s9, v_s10, v_s11, v_s12;
	logic [31:0] p_s9, p_s10, p_s11, p_s12, t_s10, tt_s11, y2_s11, y1_s12, y2_s12;
	logic f_s9, f_s10, f_s11, f_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s9, v_s10, v_s11, v_s12, m_axis_tvalid} <= '0;
		end else if (en) begin
			{v_s9, v_s10, v_s11, v_s12, m_axis_tvalid} <= {dv2_vld, v_s9, v_s10, v_s11, v_s12};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s9 <= dv2_side[1] ? (dv2_q << 1) : dv2_q;
			f_s9 <= dv2_side[0];
			p_s10 <= p_s9;
			t_s10 <= asr(p_s9, 8);
			f_s10 <= f_s9;
			p_s11 <= p_s10;
			tt_s11 <= mul32(t_s10, t_s10);
			y2_s11 <= asr(mul32(K_P_X2, p_s10), 16);
			f_s11 <= f_s10;
			p_s12 <= p_s11;
			y1_s12 <= asr(mul32(tt_s11, K_P_X1), 16);
			y2_s12 <= y2_s11;
			f_s12 <= f_s11;
			m_axis_tdata <= f_s12 ? '0 : p_s12 + asr(y1_s12 + y2_s12 + K_P_OFS, 4);
			m_axis_tuser <= f_s12;
		end
	end
endmodule

### dv/tb_barometric_pressure_compensation.sv
// self-checking testbench for the barometric pressure compensation pipeline
`timescale 1ns / 1ps
module tb_barometric_pressure_compensation;
	import bpc_pkg::*;

	typedef struct packed {
		logic [31:0] pa;
		logic        fault;
	} pres_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [RegIdxW-1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] coef [NumRegs];
	pres_res_t pending_pres[$];
	int n_mismatch = 0;
	int n_cycles = 0;
	bit rx_idle_on = 1;

	barometric_pressure_compensation dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] m32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	function automatic logic [31:0] s16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic pres_res_t compensate(input logic [15:0] ut, input logic [15:0] up);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, t, nm, dm, q;
		logic neg;
		pres_res_t r;
		ac1 = s16(coef[REG_AC1_AC2][31:16]);
		ac2 = s16(coef[REG_AC1_AC2][15:0]);
		ac3 = s16(coef[REG_AC3_AC4][31:16]);
		ac4 = {16'd0, coef[REG_AC3_AC4][15:0]};
		ac5 = {16'd0, coef[REG_AC5_AC6][31:16]};
		ac6 = {16'd0, coef[REG_AC5_AC6][15:0]};
		b1 = s16(coef[REG_B1_B2][31:16]);
		b2 = s16(coef[REG_B1_B2][15:0]);
		mc = s16(coef[REG_MC_MD][31:16]);
		md = s16(coef[REG_MC_MD][15:0]);
		r = '{pa: 32'd0, fault: 1'b1};
		x1 = sra(m32({16'd0, ut} - ac6, ac5), 15);
		den = x1 + md;
		if (den == 0)
			return r;
		nm = m32(mc, 32'd2048);
		dm = den;
		neg = nm[31] ^ den[31];
		if (nm[31]) nm = -nm;
		if (dm[31]) dm = -dm;
		q = nm / dm;
		x2 = neg ? -q : q;
		b5 = x1 + x2;
		b6 = b5 - 32'd4000;
		sq = sra(m32(b6, b6), 12);
		x1 = sra(m32(b2, sq), 11);
		x2 = sra(m32(ac2, b6), 11);
		x3 = x1 + x2;
		b3 = sra(m32(ac1, 32'd4) + x3 + 32'd2, 2);
		x1 = sra(m32(ac3, b6), 13);
		x2 = sra(m32(b1, sq), 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = m32(ac4, x3 + 32'd32768) >> 15;
		b7 = m32({16'd0, up} - b3, 32'd50000);
		if (b4 == 0)
			return r;
		if (!b7[31])
			p = (b7 << 1) / b4;
		else
			p = (b7 / b4) << 1;
		t = sra(p, 8);
		x1 = m32(t, t);
		x1 = sra(m32(x1, 32'd3038), 16);
		x2 = sra(m32(-32'd7357, p), 16);
		p = p + sra(x1 + x2 + 32'd3791, 4);
		r = '{pa: p, fault: 1'b0};
		return r;
	endfunction

	task automatic write_coef(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
		cfg_idx <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NumRegs)
			coef[idx] = val;
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_sample(input logic [15:0] ut, input logic [15:0] up, input bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 7) : 0;
		if (w > 0) begin
			s_axis_tvalid <= 0;
			repeat (w) @(negedge clk);
		end
		s_axis_tdata <= {up, ut};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		pending_pres.push_back(compensate(ut, up));
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_pres.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic load_datasheet();
		write_coef(REG_AC1_AC2, {16'd408, -16'sd72});
		write_coef(REG_AC3_AC4, {-16'sd14383, 16'd32741});
		write_coef(REG_AC5_AC6, {16'd32757, 16'd23153});
		write_coef(REG_B1_B2, {16'd6190, 16'd4});
		write_coef(REG_MC_MD, {-16'sd8711, 16'd2868});
	endtask

	task automatic test_directed();
		load_datasheet();
		send_sample(16'd27898, 16'd23843, 1);
		send_sample(16'h0000, 16'h0000, 1);
		send_sample(16'hFFFF, 16'hFFFF, 1);
		send_sample(16'hFFFF, 16'h0000, 1);
		send_sample(16'h0000, 16'hFFFF, 1);
		send_sample(16'h8000, 16'h7FFF, 0);
		send_sample(16'h5555, 16'hAAAA, 0);
		drain();
		// zero temperature divisor: ut equals ac6 and md is zero
		write_coef(REG_MC_MD, {16'h8000, 16'd0});
		send_sample(16'd23153, 16'd100, 1);
		send_sample(16'd23154, 16'd100, 1);
		drain();
		// zero pressure divisor: ac4 is zero
		write_coef(REG_MC_MD, {16'h7FFF, 16'h7FFF});
		write_coef(REG_AC3_AC4, {16'h7FFF, 16'd0});
		send_sample(16'd30000, 16'd40000, 1);
		drain();
		write_coef(REG_AC1_AC2, 32'hFFFF_FFFF);
		write_coef(REG_AC3_AC4, 32'h8000_FFFF);
		write_coef(REG_AC5_AC6, 32'hFFFF_FFFF);
		write_coef(REG_B1_B2, 32'h8000_8000);
		write_coef(REG_MC_MD, 32'h8000_8001);
		send_sample(16'hFFFF, 16'h1234, 1);
		send_sample(16'h0000, 16'hFFFF, 1);
		send_sample(16'h7FFF, 16'h8000, 0);
		drain();
		// out of range index is ignored
		write_coef(3'd7, 32'h1234_5678);
		write_coef(3'd5, 32'hDEAD_BEEF);
		send_sample(16'd27898, 16'd23843, 1);
		drain();
	endtask

	task automatic test_random();
		logic [15:0] ac6;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) begin
				load_datasheet();
				write_coef(REG_AC1_AC2, {16'($urandom_range(0, 8000) - 4000),
					16'($urandom_range(0, 4000) - 2000)});
				write_coef(REG_MC_MD, {16'($urandom_range(0, 20000) - 20000),
					16'($urandom_range(1000, 5000))});
			end else begin
				for (int i = 0; i < NumRegs; i++)
					write_coef(i[RegIdxW-1:0], $urandom);
			end
			ac6 = coef[REG_AC5_AC6][15:0];
			rx_idle_on = (ph % 3) != 2;
			for (int n = 0; n < 100; n++) begin
				if (ph < 6 && $urandom_range(0, 3) != 0)
					send_sample(16'(ac6 + $urandom_range(0, 8000)),
						16'($urandom_range(15000, 45000)), ph % 3 != 2);
				else
					send_sample(16'($urandom), 16'($urandom), ph % 3 != 2);
			end
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < NumRegs; i++)
			coef[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_random();
		if (n_mismatch == 0)
			$display("barometric_pressure_compensation: match");
		else
			$display("barometric_pressure_compensation: mismatch");
		$finish;
	end

	initial begin
		int w;
		forever begin
			@(negedge clk);
			w = rx_idle_on ? $urandom_range(0, 7) : 0;
			if (w > 0) begin
				m_axis_tready <= 0;
				repeat (w) @(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		pres_res_t want;
		n_cycles <= n_cycles + 1;
		if (n_cycles > 500000) begin
			$display("barometric_pressure_compensation: mismatch");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pres.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected transaction pa=%h fault=%b", m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_pres.pop_front();
				if (want.pa !== m_axis_tdata || want.fault !== m_axis_tuser) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("pa exp %h got %h, fault exp %b got %b",
							want.pa, m_axis_tdata, want.fault, m_axis_tuser);
				end
			end
		end
	end

endmodule
